### sv/uart_tx_frame_serializer_defines.svh
// ---------------------------------------------------------------------------
// uart tx frame serializer assertion macros
// shared concurrent check wrappers, compiled out with ASSERT_OFF
// ---------------------------------------------------------------------------
`ifndef UART_TX_FRAME_SERIALIZER_DEFINES_SVH
`define UART_TX_FRAME_SERIALIZER_DEFINES_SVH

`ifndef ASSERT_OFF

// property must hold on every clock edge outside reset
`define UTX_ASSERT(lbl, clk_i, rstn_i, prop) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) prop) \
        else $error("uart tx check failed");

// condition must never be true outside reset
`define UTX_ASSERT_NEVER(lbl, clk_i, rstn_i, cond) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) !(cond)) \
        else $error("uart tx forbidden condition seen");

`else

`define UTX_ASSERT(lbl, clk_i, rstn_i, prop)
`define UTX_ASSERT_NEVER(lbl, clk_i, rstn_i, cond)

`endif

`endif

### sv/uarttx_pkg.sv
// ---------------------------------------------------------------------------
// uart tx package
// register indexes, codes and reset values of the uart frame serializer
// ---------------------------------------------------------------------------
package uarttx_pkg;

    // default width of the bit period counter
    localparam int BIT_TIME_WIDTH_DEF = 16;

    // smallest width that holds the bit time reset value
    localparam int BIT_TIME_RESET_WIDTH = 7;

    // configuration register indexes
    localparam logic [2:0] REG_DATA_BITS   = 3'd0;
    localparam logic [2:0] REG_PARITY_MODE = 3'd1;
    localparam logic [2:0] REG_STOP_BITS   = 3'd2;
    localparam logic [2:0] REG_INVERT_TX   = 3'd3;
    localparam logic [2:0] REG_BIT_TIME    = 3'd4;

    // parity codes
    localparam logic [2:0] PAR_NONE  = 3'd0;
    localparam logic [2:0] PAR_EVEN  = 3'd1;
    localparam logic [2:0] PAR_ODD   = 3'd2;
    localparam logic [2:0] PAR_MARK  = 3'd3;
    localparam logic [2:0] PAR_SPACE = 3'd4;

    // item kinds
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // framing
    localparam logic [3:0] FULL_DATA_BITS = 4'd8;
    localparam logic [3:0] MIN_DATA_BITS  = 4'd5;
    localparam logic [3:0] MAX_SHORT_BITS = 4'd7;
    localparam logic [1:0] ONE_STOP_BIT   = 2'd1;
    localparam logic [1:0] TWO_STOP_BITS  = 2'd2;

    // register reset values
    localparam logic [3:0] DATA_BITS_RESET   = 4'd8;
    localparam logic [2:0] PARITY_RESET      = PAR_NONE;
    localparam logic [1:0] STOP_BITS_RESET   = 2'd1;
    localparam logic       INVERT_RESET      = 1'b0;
    localparam int         BIT_TIME_RESET    = 104;

    // result word layout
    typedef struct packed {
        logic [3:0] pad;
        logic       busy_res;
        logic       frame_done;
        logic       accepted;
        logic       line_level;
    } result_t;

endpackage

### sv/uart_tx_frame_serializer.sv
// ---------------------------------------------------------------------------
// uart tx frame serializer
// builds start/data/parity/stop frames and shifts one bit per bit period
// ---------------------------------------------------------------------------
//
//  channel   dir  fields
//  s_*       in   tuser: mode | tdata: data[7:0]
//  m_*       out  tdata: line_level, accepted, frame_done, busy_res, pad
//  cfg_*     in   cfg_index selects register, cfg_data carries its value
//
//  one request per clock while the output register can take it; each accepted
//  request yields one result in the next cycle, held in the output register until taken
//  a request is taken while the output register is empty or being drained
//  the frame shifter, bit counter and tick counter update at acceptance
//  reset clears the frame state; the line idles high (low when inverted)
//
`include "uart_tx_frame_serializer_defines.svh"

module uart_tx_frame_serializer
    import uarttx_pkg::*;
#(
    parameter int BIT_TIME_WIDTH = BIT_TIME_WIDTH_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // input stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // [7:0] data
    input  logic                      s_tuser,   // [0] mode
    // result stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [7:0]                m_tdata,   // [0] line_level, [1] accepted,
                                                 // [2] frame_done, [3] busy_res
    // configuration
    input  logic                      cfg_wr_en,
    input  logic [2:0]                cfg_index,
    input  logic [BIT_TIME_WIDTH-1:0] cfg_data
);

    // bit time storage is at least wide enough for its reset value
    localparam int BTW = (BIT_TIME_WIDTH > BIT_TIME_RESET_WIDTH) ?
                         BIT_TIME_WIDTH : BIT_TIME_RESET_WIDTH;

    // configuration registers
    logic [3:0]                data_bits_reg;
    logic [2:0]                parity_mode_reg;
    logic [1:0]                stop_bits_reg;
    logic                      invert_tx_reg;
    logic [BTW-1:0]            bit_time_reg;

    // frame state
    logic [11:0]               frame_shift_reg, frame_shift_next;
    logic [3:0]                bits_rem_reg, bits_rem_next;
    logic [BIT_TIME_WIDTH-1:0] tick_count_reg, tick_count_next;
    logic                      line_out_reg, line_out_next;

    // output register
    logic                      m_valid_reg;
    result_t                   result_reg, result_next;

    logic                      in_fire;
    logic                      busy;

    // frame build signals
    logic [3:0]                eff_db;
    logic [7:0]                data_mask;
    logic [7:0]                data_m;
    logic                      par_en;
    logic                      par_bit;
    logic [1:0]                stop_cnt;
    logic [3:0]                par_pos;
    logic [3:0]                stop_pos;
    logic [11:0]               stop_mask;
    logic [11:0]               frame_raw;
    logic [3:0]                frame_len;

    // tick signals
    logic [BIT_TIME_WIDTH-1:0] tick_inc;
    logic [BTW-1:0]            tick_inc_ext;
    logic [BTW-1:0]            bt_eff;
    logic                      bit_hit;

    // result flags seen by the checks
    logic                      out_done;
    logic                      out_accepted;

    assign busy     = (bits_rem_reg != 4'd0);
    assign s_tready = !m_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = result_reg;

    // effective framing from the configuration
    always_comb
    begin
        if (data_bits_reg >= MIN_DATA_BITS && data_bits_reg <= MAX_SHORT_BITS)
        begin
            eff_db = data_bits_reg;
        end
        else
        begin
            eff_db = FULL_DATA_BITS;
        end
        data_mask = 8'hFF >> (FULL_DATA_BITS - eff_db);
        data_m    = s_tdata & data_mask;
        par_en    = (parity_mode_reg == PAR_EVEN) || (parity_mode_reg == PAR_ODD) ||
                    (parity_mode_reg == PAR_MARK) || (parity_mode_reg == PAR_SPACE);
        case (parity_mode_reg)
            PAR_EVEN:  par_bit = ^data_m;
            PAR_ODD:   par_bit = ~(^data_m);
            PAR_MARK:  par_bit = 1'b1;
            default:   par_bit = 1'b0;
        endcase
        stop_cnt  = (stop_bits_reg == TWO_STOP_BITS) ? TWO_STOP_BITS : ONE_STOP_BIT;
        stop_mask = (stop_cnt == TWO_STOP_BITS) ? 12'd3 : 12'd1;
        par_pos   = 4'd1 + eff_db;
        stop_pos  = par_pos + {3'b000, par_en};
        frame_len = stop_pos + {2'b00, stop_cnt};
        frame_raw = {3'b000, data_m, 1'b0}
                  | ({11'd0, par_bit & par_en} << par_pos)
                  | (stop_mask << stop_pos);
    end

    // bit period counter compare
    always_comb
    begin
        tick_inc     = tick_count_reg + 1'b1;
        tick_inc_ext = BTW'(tick_inc);
        bt_eff       = (bit_time_reg == '0) ? BTW'(1) : bit_time_reg;
        bit_hit      = (tick_inc_ext >= bt_eff) || (tick_inc == '0);
    end

    // next frame state and result for the incoming request
    always_comb
    begin
        frame_shift_next = frame_shift_reg;
        bits_rem_next    = bits_rem_reg;
        tick_count_next  = tick_count_reg;
        line_out_next    = line_out_reg;
        result_next      = '0;
        if (s_tuser == MODE_LOAD)
        begin
            if (!busy)
            begin
                frame_shift_next   = invert_tx_reg ? ~frame_raw : frame_raw;
                bits_rem_next      = frame_len;
                tick_count_next    = '0;
                result_next.accepted = 1'b1;
            end
        end
        else if (busy)
        begin
            tick_count_next = tick_inc;
            if (bit_hit)
            begin
                tick_count_next  = '0;
                line_out_next    = frame_shift_reg[0];
                frame_shift_next = frame_shift_reg >> 1;
                bits_rem_next    = bits_rem_reg - 4'd1;
                if (bits_rem_reg == 4'd1)
                begin
                    result_next.frame_done = 1'b1;
                end
            end
        end
        result_next.line_level = line_out_next;
        result_next.busy_res   = (bits_rem_next != 4'd0);
    end

    // frame state and line level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_shift_reg <= '0;
            bits_rem_reg    <= '0;
            tick_count_reg  <= '0;
            line_out_reg    <= 1'b1;
        end
        else if (in_fire)
        begin
            frame_shift_reg <= frame_shift_next;
            bits_rem_reg    <= bits_rem_next;
            tick_count_reg  <= tick_count_next;
            line_out_reg    <= line_out_next;
        end
        else if (cfg_wr_en && cfg_index == REG_INVERT_TX && !busy)
        begin
            line_out_reg <= !cfg_data[0];
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_bits_reg   <= DATA_BITS_RESET;
            parity_mode_reg <= PARITY_RESET;
            stop_bits_reg   <= STOP_BITS_RESET;
            invert_tx_reg   <= INVERT_RESET;
            bit_time_reg    <= BTW'(BIT_TIME_RESET);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DATA_BITS:   data_bits_reg   <= cfg_data[3:0];
                REG_PARITY_MODE: parity_mode_reg <= cfg_data[2:0];
                REG_STOP_BITS:   stop_bits_reg   <= cfg_data[1:0];
                REG_INVERT_TX:   invert_tx_reg   <= cfg_data[0];
                REG_BIT_TIME:    bit_time_reg    <= BTW'(cfg_data);
                default:         ;
            endcase
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            result_reg <= result_next;
        end
    end

    // flags of the result waiting in the output register
    assign out_done     = m_valid_reg && result_reg.frame_done;
    assign out_accepted = m_valid_reg && result_reg.accepted;

    // checks
    `UTX_ASSERT(a_done_ends_busy, clk, rst_n, out_done |-> !result_reg.busy_res)
    `UTX_ASSERT(a_accept_starts_busy, clk, rst_n, out_accepted |-> result_reg.busy_res)
    `UTX_ASSERT(a_idle_tick_clear, clk, rst_n, (bits_rem_reg == 4'd0) |-> (tick_count_reg == '0))
    `UTX_ASSERT_NEVER(a_frame_len_max, clk, rst_n, bits_rem_reg > 4'd12)

endmodule

### tb/uart_tx_frame_serializer_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// uart tx frame serializer testbench
// sends load and tick requests through the input stream, mirrors the frame
// builder and bit timer in a line predictor, and checks every result word
// in order while both stream sides idle and stall at random
// ---------------------------------------------------------------------------
module uart_tx_frame_serializer_tb;
    import uarttx_pkg::*;

    localparam int         BTW            = BIT_TIME_WIDTH_DEF;
    localparam logic [2:0] REG_UNUSED     = 3'd7;
    localparam int         SEGMENTS       = 12;
    localparam int         ITEMS_PER_SEG  = 85;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         STALL_LIMIT    = 2000;

    // predicts line level and frame status per request, holds the expected words
    class tx_line_predictor;
        // configuration mirror
        logic [3:0]     data_bits_q;
        logic [2:0]     parity_q;
        logic [1:0]     stop_bits_q;
        logic           invert_q;
        logic [BTW-1:0] bit_time_q;
        // frame state mirror
        logic [11:0]    frame_q;
        logic [3:0]     bits_left;
        logic [BTW-1:0] tick_cnt;
        logic           line_q;
        result_t        line_results_q[$];
        int             errors;
        int             results_seen;
        int             frames_started;
        int             frames_done;
        int             loads_rejected;

        function new();
            data_bits_q    = DATA_BITS_RESET;
            parity_q       = PARITY_RESET;
            stop_bits_q    = STOP_BITS_RESET;
            invert_q       = INVERT_RESET;
            bit_time_q     = BTW'(BIT_TIME_RESET);
            frame_q        = '0;
            bits_left      = '0;
            tick_cnt       = '0;
            line_q         = 1'b1;
            errors         = 0;
            results_seen   = 0;
            frames_started = 0;
            frames_done    = 0;
            loads_rejected = 0;
        endfunction

        function bit busy();
            return bits_left != 4'd0;
        endfunction

        function int pending();
            return line_results_q.size();
        endfunction

        function void write_reg(logic [2:0] idx, logic [BTW-1:0] val);
            case (idx)
                REG_DATA_BITS:   data_bits_q = val[3:0];
                REG_PARITY_MODE: parity_q    = val[2:0];
                REG_STOP_BITS:   stop_bits_q = val[1:0];
                REG_INVERT_TX:
                begin
                    invert_q = val[0];
                    // idle line follows the new polarity at once
                    if (bits_left == 4'd0)
                        line_q = ~val[0];
                end
                REG_BIT_TIME:    bit_time_q  = val;
                default:         ;
            endcase
        endfunction

        function void note_request(logic mode, logic [7:0] data);
            result_t        exp;
            int             dbits;
            int             nbits;
            int             nstop;
            int             i;
            logic [7:0]     payload;
            logic [31:0]    frame;
            logic           par_bit;
            logic [BTW-1:0] period;

            exp = '0;
            if (mode == MODE_LOAD)
            begin
                if (bits_left == 4'd0)
                begin
                    // out of range data widths fall back to a full byte
                    if (data_bits_q >= MIN_DATA_BITS && data_bits_q <= MAX_SHORT_BITS)
                        dbits = int'(data_bits_q);
                    else
                        dbits = int'(FULL_DATA_BITS);
                    payload = data;
                    for (i = 0; i < 8; i++)
                        if (i >= dbits)
                            payload[i] = 1'b0;
                    // start bit low at bit 0, data lsb first
                    frame = 32'(payload) << 1;
                    nbits = 1 + dbits;
                    if (parity_q >= PAR_EVEN && parity_q <= PAR_SPACE)
                    begin
                        case (parity_q)
                            PAR_EVEN: par_bit = ^payload;
                            PAR_ODD:  par_bit = ~(^payload);
                            PAR_MARK: par_bit = 1'b1;
                            default:  par_bit = 1'b0;
                        endcase
                        frame[nbits] = par_bit;
                        nbits++;
                    end
                    nstop = (stop_bits_q == TWO_STOP_BITS) ? 2 : int'(ONE_STOP_BIT);
                    for (i = 0; i < nstop; i++)
                    begin
                        frame[nbits] = 1'b1;
                        nbits++;
                    end
                    if (invert_q)
                        frame = ~frame;
                    frame_q      = frame[11:0];
                    bits_left    = 4'(nbits);
                    tick_cnt     = '0;
                    exp.accepted = 1'b1;
                    frames_started++;
                end
                else
                    loads_rejected++;
            end
            else if (bits_left != 4'd0)
            begin
                // zero bit time behaves as one tick per bit
                period   = (bit_time_q == '0) ? BTW'(1) : bit_time_q;
                tick_cnt = tick_cnt + 1'b1;
                if (tick_cnt >= period || tick_cnt == '0)
                begin
                    tick_cnt  = '0;
                    line_q    = frame_q[0];
                    frame_q   = frame_q >> 1;
                    bits_left = bits_left - 4'd1;
                    if (bits_left == 4'd0)
                    begin
                        exp.frame_done = 1'b1;
                        frames_done++;
                    end
                end
            end
            exp.line_level = line_q;
            exp.busy_res   = bits_left != 4'd0;
            line_results_q.push_back(exp);
        endfunction

        function void compare_field(string name, logic [3:0] e, logic [3:0] a);
            if (a !== e)
            begin
                $error("%s: expected %0d, got %0d", name, e, a);
                errors++;
            end
        endfunction

        function void check_result(logic [7:0] word);
            result_t got;
            result_t exp;

            got = result_t'(word);
            results_seen++;
            if (line_results_q.size() == 0)
            begin
                $error("result %h arrived with no request waiting", word);
                errors++;
                return;
            end
            exp = line_results_q.pop_front();
            compare_field("line_level", 4'(exp.line_level), 4'(got.line_level));
            compare_field("accepted", 4'(exp.accepted), 4'(got.accepted));
            compare_field("frame_done", 4'(exp.frame_done), 4'(got.frame_done));
            compare_field("busy_res", 4'(exp.busy_res), 4'(got.busy_res));
            compare_field("pad", 4'd0, got.pad);
        endfunction
    endclass

    logic           clk;
    logic           rst_n;
    logic           s_tvalid;
    logic           s_tready;
    logic [7:0]     s_tdata;    // [7:0] data
    logic           s_tuser;    // [0] mode
    logic           m_tvalid;
    logic           m_tready;
    logic [7:0]     m_tdata;    // [0] line_level, [1] accepted, [2] frame_done,
                                // [3] busy_res, [7:4] zero
    logic           cfg_wr_en;
    logic [2:0]     cfg_index;
    logic [BTW-1:0] cfg_data;

    tx_line_predictor pred;
    int               send_idle_pct;
    int               recv_idle_pct;
    int               hold_left;
    int               requests_sent;
    int               stall_cycles;

    uart_tx_frame_serializer dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // result side ready, with random stalls and a long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result checking and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                pred.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // offer one request, with random gaps before it, and wait for acceptance
    task automatic send_request(input logic mode, input logic [7:0] data);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= data;
        do
            @(posedge clk);
        while (!s_tready);
        pred.note_request(mode, data);
        requests_sent++;
    endtask

    // tick until the frame in flight has gone out
    task automatic finish_frame();
        while (pred.busy())
            send_request(MODE_TICK, 8'($urandom));
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pred.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [BTW-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        pred.write_reg(idx, val);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // random framing, stray high bits included, mostly short bit times
    task automatic random_setup();
        if ($urandom_range(9) == 0)
            cfg_write(REG_DATA_BITS, BTW'($urandom));
        else
            cfg_write(REG_DATA_BITS, BTW'($urandom_range(5, 8)));
        cfg_write(REG_PARITY_MODE, BTW'($urandom));
        cfg_write(REG_STOP_BITS, BTW'($urandom));
        cfg_write(REG_INVERT_TX, BTW'($urandom));
        if ($urandom_range(5) == 0)
            cfg_write(REG_BIT_TIME, BTW'($urandom_range(4, 24)));
        else
            cfg_write(REG_BIT_TIME, BTW'($urandom_range(0, 3)));
        if ($urandom_range(3) == 0)
            cfg_write(3'($urandom_range(5, 7)), BTW'($urandom));
    endtask

    initial
    begin : stimulus
        int seg;
        int seg_end;
        int pick;

        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        m_tready      = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = 0;
        requests_sent = 0;
        stall_cycles  = 0;
        pred          = new();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // tick with no frame in flight is ignored
        send_request(MODE_TICK, 8'h00);

        // short data, even parity, two stops, one tick per bit; stray data bits
        // masked; load while busy turned away
        drain();
        cfg_write(REG_DATA_BITS, BTW'(MIN_DATA_BITS));
        cfg_write(REG_PARITY_MODE, BTW'(PAR_EVEN));
        cfg_write(REG_STOP_BITS, BTW'(TWO_STOP_BITS));
        cfg_write(REG_BIT_TIME, BTW'(1));
        send_request(MODE_LOAD, 8'hFF);
        send_request(MODE_LOAD, 8'h00);
        finish_frame();

        // out of range width and stop count, odd parity, inverted, zero bit time
        drain();
        cfg_write(REG_DATA_BITS, BTW'(4'hF));
        cfg_write(REG_PARITY_MODE, BTW'(PAR_ODD));
        cfg_write(REG_STOP_BITS, BTW'(2'd3));
        cfg_write(REG_INVERT_TX, BTW'(1));
        cfg_write(REG_BIT_TIME, BTW'(0));
        cfg_write(REG_UNUSED, '1);
        send_request(MODE_LOAD, 8'hA5);
        send_request(MODE_TICK, 8'hFF);
        send_request(MODE_TICK, 8'h00);

        // longest bit time mid-frame, then shortened mid-bit; invert while busy
        drain();
        cfg_write(REG_BIT_TIME, '1);
        send_request(MODE_TICK, 8'h00);
        send_request(MODE_TICK, 8'h00);
        send_request(MODE_TICK, 8'h00);
        drain();
        cfg_write(REG_INVERT_TX, BTW'(0));
        cfg_write(REG_BIT_TIME, BTW'(2));
        send_request(MODE_TICK, 8'h00);
        drain();
        cfg_write(REG_BIT_TIME, BTW'(1));
        finish_frame();

        // random part: mostly whole frames, some cut short, some noise
        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            drain();
            random_setup();
            case (seg / 4)
                0:
                begin
                    send_idle_pct = 25;
                    recv_idle_pct = 71;
                end
                1:
                begin
                    send_idle_pct = 71;
                    recv_idle_pct = 25;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (seg == 8)
                hold_left = HOLD_CYCLES;
            seg_end = requests_sent + ITEMS_PER_SEG;
            while (requests_sent < seg_end)
            begin
                pick = $urandom_range(99);
                if (pick < 80)
                begin
                    send_request(MODE_LOAD, 8'($urandom));
                    while (pred.busy() && requests_sent < seg_end)
                    begin
                        if ($urandom_range(99) < 3)
                            send_request(MODE_LOAD, 8'($urandom));
                        else
                            send_request(MODE_TICK, 8'($urandom));
                    end
                end
                else if (pick < 90)
                begin
                    send_request(MODE_LOAD, 8'($urandom));
                    repeat ($urandom_range(0, 8))
                        send_request(MODE_TICK, 8'($urandom));
                end
                else
                begin
                    repeat ($urandom_range(1, 4))
                        send_request(1'($urandom), 8'($urandom));
                end
            end
        end

        drain();
        $display("run covered %0d requests and %0d results over %0d framing setups",
                 requests_sent, pred.results_seen, SEGMENTS + 3);
        $display("frames started %0d, completed %0d, loads turned away while busy %0d",
                 pred.frames_started, pred.frames_done, pred.loads_rejected);
        if (pred.errors == 0 && pred.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
